// File: rtl/asn1_tlv_stream_parser_top_macros.svh
// ----------------------------------------------------------------------------
// asn1 tlv stream parser assertion macros
// shared concurrent assertion forms for the parser modules
// ----------------------------------------------------------------------------
`ifndef ASN1_TLV_STREAM_PARSER_TOP_MACROS_SVH
`define ASN1_TLV_STREAM_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ATLV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ATLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/atlv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atlv_pkg
// types and codes shared by the asn1 tlv stream parser
// ----------------------------------------------------------------------------
package atlv_pkg;

   localparam int unsigned LENGTH_BITS_DEF = 32;
   localparam int unsigned TAG_W           = 32;
   localparam int unsigned LEN_OUT_W       = 32;

   // parser phases
   localparam logic [2:0] PH_ID      = 3'd0;
   localparam logic [2:0] PH_HIGH    = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_LONG    = 3'd3;
   localparam logic [2:0] PH_CONTENT = 3'd4;

   // byte kinds
   localparam logic [2:0] KIND_ID      = 3'd0;
   localparam logic [2:0] KIND_HIGH    = 3'd1;
   localparam logic [2:0] KIND_LEN     = 3'd2;
   localparam logic [2:0] KIND_LONG    = 3'd3;
   localparam logic [2:0] KIND_CONTENT = 3'd4;

   localparam logic [4:0] TAG_ESCAPE = 5'b11111;

   typedef struct packed {
      logic [2:0]           byte_kind;
      logic [1:0]           tag_class;
      logic                 constructed;
      logic [TAG_W-1:0]     tag_number;
      logic [LEN_OUT_W-1:0] content_length;
      logic [7:0]           byte_out;
      logic                 element_end;
      logic                 truncated;
      logic                 oversize;
   } result_type;

endpackage

// File: rtl/atlv_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atlv_req_if
// byte stream channel into the parser
// ----------------------------------------------------------------------------
interface atlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_data;

   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// File: rtl/atlv_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atlv_rsp_if
// labelled byte channel out of the parser
// ----------------------------------------------------------------------------
interface atlv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_kind;
   logic [1:0]  tag_class;
   logic        constructed;
   logic [31:0] tag_number;
   logic [31:0] content_length;
   logic [7:0]  byte_out;
   logic        element_end;
   logic        truncated;
   logic        oversize;

   modport source (output valid, output byte_kind, output tag_class, output constructed,
                   output tag_number, output content_length, output byte_out,
                   output element_end, output truncated, output oversize, input ready);
   modport sink   (input valid, input byte_kind, input tag_class, input constructed,
                   input tag_number, input content_length, input byte_out,
                   input element_end, input truncated, input oversize, output ready);
endinterface

// File: rtl/asn1_tlv_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asn1_tlv_stream_parser_top
// splits an asn1 ber byte stream into labelled tlv elements, unless rsp_ch stalls, one byte a cycle
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req_ch   in   data_byte, end_of_data
//  rsp_ch   out  byte_kind, tag_class, constructed, tag_number, content_length,
//                byte_out, element_end, truncated, oversize
//
//  one byte per cycle sustained while rsp_ch does not stall; a transfer on req_ch
//  reaches rsp_ch through the input register, then the result register
//  the parse state advances as a byte moves from the input to the result register
//  synchronous active-high reset returns the parser to the identifier phase
//  a stall on rsp_ch holds the result register and a filled input register; req_ch ready follows within the cycle
// ----------------------------------------------------------------------------
`include "asn1_tlv_stream_parser_top_macros.svh"

module asn1_tlv_stream_parser_top
   import atlv_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
   input logic   clock,
   input logic   reset,
   atlv_req_if.sink   req_ch,
   atlv_rsp_if.source rsp_ch
);

   localparam int unsigned LEN_W = (LENGTH_BITS >= 32) ? 32 : LENGTH_BITS;

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_eod_ff;
   logic       out_vld_ff;
   result_type out_ff;
   result_type step_res;
   logic       advance;
   logic       req_take;

   assign advance  = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_vld_ff || advance;

   atlv_core #(
      .LEN_W (LEN_W)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .data_byte   (in_byte_ff),
      .end_of_data (in_eod_ff),
      .result      (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.data_byte;
         in_eod_ff  <= req_ch.end_of_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.byte_kind      = out_ff.byte_kind;
   assign rsp_ch.tag_class      = out_ff.tag_class;
   assign rsp_ch.constructed    = out_ff.constructed;
   assign rsp_ch.tag_number     = out_ff.tag_number;
   assign rsp_ch.content_length = out_ff.content_length;
   assign rsp_ch.byte_out       = out_ff.byte_out;
   assign rsp_ch.element_end    = out_ff.element_end;
   assign rsp_ch.truncated      = out_ff.truncated;
   assign rsp_ch.oversize       = out_ff.oversize;

   `ATLV_ASSERT_NOW(a_trunc_ends_element, clock, reset, out_vld_ff && out_ff.truncated, out_ff.element_end, "truncated result without element end")
   `ATLV_ASSERT_NEXT(a_held_byte_kept, clock, reset, in_vld_ff && !advance, in_vld_ff && $stable(in_byte_ff), "stalled input byte lost")

endmodule

// File: rtl/atlv_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atlv_core
// per-element parse state and the one-byte step that labels each byte
// ----------------------------------------------------------------------------
`include "asn1_tlv_stream_parser_top_macros.svh"

module atlv_core
   import atlv_pkg::*;
#(
   parameter int unsigned LEN_W = LENGTH_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] data_byte,
   input  logic       end_of_data,
   output result_type result
);

   logic [2:0]       phase_ff, phase_in;
   logic [1:0]       class_ff, class_in;
   logic             cons_ff, cons_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [6:0]       lbl_ff, lbl_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic             over_ff, over_in;

   logic [LEN_W+7:0] len_shift;
   logic             done;
   logic             trunc;
   logic [2:0]       kind;

   assign len_shift = {len_ff, data_byte};

   always_comb begin
      phase_in = phase_ff;
      class_in = class_ff;
      cons_in  = cons_ff;
      tag_in   = tag_ff;
      lbl_in   = lbl_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      over_in  = over_ff;
      done     = 1'b0;
      kind     = KIND_ID;

      unique case (phase_ff)
         PH_HIGH: begin
            kind = KIND_HIGH;
            if (|tag_ff[TAG_W-1:TAG_W-7]) begin
               tag_in  = '1;
               over_in = 1'b1;
            end else begin
               tag_in = {tag_ff[TAG_W-8:0], data_byte[6:0]};
            end
            if (!data_byte[7]) begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            kind = KIND_LEN;
            if (data_byte[7]) begin
               len_in = '0;
               lbl_in = data_byte[6:0];
               if (data_byte[6:0] == 7'd0) begin
                  done     = 1'b1;
                  phase_in = PH_ID;
               end else begin
                  phase_in = PH_LONG;
               end
            end else begin
               len_in = LEN_W'(data_byte);
               if (data_byte == 8'd0) begin
                  done     = 1'b1;
                  phase_in = PH_ID;
               end else begin
                  cnt_in   = LEN_W'(data_byte);
                  phase_in = PH_CONTENT;
               end
            end
         end
         PH_LONG: begin
            kind = KIND_LONG;
            if (|len_shift[LEN_W+7:LEN_W]) begin
               len_in  = '1;
               over_in = 1'b1;
            end else begin
               len_in = len_shift[LEN_W-1:0];
            end
            lbl_in = lbl_ff - 7'd1;
            if (lbl_ff == 7'd1) begin
               if (len_in == '0) begin
                  done     = 1'b1;
                  phase_in = PH_ID;
               end else begin
                  cnt_in   = len_in;
                  phase_in = PH_CONTENT;
               end
            end
         end
         PH_CONTENT: begin
            kind   = KIND_CONTENT;
            cnt_in = cnt_ff - {{(LEN_W-1){1'b0}}, 1'b1};
            if (cnt_in == '0) begin
               done     = 1'b1;
               phase_in = PH_ID;
            end
         end
         default: begin
            // identifier byte, also taken for unused phase codes
            kind     = KIND_ID;
            class_in = data_byte[7:6];
            cons_in  = data_byte[5];
            lbl_in   = '0;
            len_in   = '0;
            cnt_in   = '0;
            over_in  = 1'b0;
            if (data_byte[4:0] == TAG_ESCAPE) begin
               tag_in   = '0;
               phase_in = PH_HIGH;
            end else begin
               tag_in   = TAG_W'(data_byte[4:0]);
               phase_in = PH_LEN;
            end
         end
      endcase

      trunc = end_of_data && !done;
      if (trunc) begin
         phase_in = PH_ID;
      end
   end

   always_comb begin
      result.byte_kind      = kind;
      result.tag_class      = class_in;
      result.constructed    = cons_in;
      result.tag_number     = tag_in;
      result.content_length = LEN_OUT_W'(len_in);
      result.byte_out       = data_byte;
      result.element_end    = done || trunc;
      result.truncated      = trunc;
      result.oversize       = over_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ID;
         class_ff <= '0;
         cons_ff  <= 1'b0;
         tag_ff   <= '0;
         lbl_ff   <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         over_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         cons_ff  <= cons_in;
         tag_ff   <= tag_in;
         lbl_ff   <= lbl_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         over_ff  <= over_in;
      end
   end

   `ATLV_ASSERT_NEXT(a_end_returns_to_id, clock, reset, step_en && result.element_end, phase_ff == PH_ID, "element end did not return to identifier phase")
   `ATLV_ASSERT_NOW(a_content_count_live, clock, reset, phase_ff == PH_CONTENT, cnt_ff != '0, "content phase with nothing left to count")
   `ATLV_ASSERT_NOW(a_long_count_live, clock, reset, phase_ff == PH_LONG, lbl_ff != 7'd0, "long length phase with no length bytes left")

endmodule

// File: dv/tb_asn1_tlv_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_asn1_tlv_stream_parser_top
// drives ber byte streams through the parser and checks every labelled byte.
// a short directed table covers the edge cases of tag, length and truncation,
// then random well-formed elements mixed with broken ones and noise follow.
// every result is compared with a hand-written label or a cycle-free parsing model.
// ----------------------------------------------------------------------------
module tb_asn1_tlv_stream_parser_top
   import atlv_pkg::*;
();

   localparam int unsigned RANDOM_BYTES = 520;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned HOLD_AFTER   = 150;
   localparam int unsigned HOLD_CYCLES  = 80;
   localparam int unsigned DRAIN_CYCLES = 6;

   typedef struct packed {
      logic [2:0]  phase;
      logic [1:0]  cls;
      logic        cons;
      logic [31:0] tag;
      logic [6:0]  len_left;
      logic [31:0] length;
      logic [31:0] content_left;
      logic        over;
   } parse_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eod;
   } body_byte_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eod;
      logic       fixed;
      result_type want;
   } dir_row_type;

   // rows with fixed set carry a hand-written label, the rest are predicted
   localparam dir_row_type DIR_TABLE [0:26] = '{
      // short tag after reset, then zero length on the final byte of the data
      '{8'h02, 1'b0, 1'b1, '{KIND_ID, 2'd0, 1'b0, 32'd2, 32'd0, 8'h02, 1'b0, 1'b0, 1'b0}},
      '{8'h00, 1'b1, 1'b1, '{KIND_LEN, 2'd0, 1'b0, 32'd2, 32'd0, 8'h00, 1'b1, 1'b0, 1'b0}},
      // private constructed high tag that saturates, then indefinite length
      '{8'hFF, 1'b0, 1'b1, '{KIND_ID, 2'd3, 1'b1, 32'd0, 32'd0, 8'hFF, 1'b0, 1'b0, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b1,
        '{KIND_LEN, 2'd3, 1'b1, 32'hFFFF_FFFF, 32'd0, 8'h80, 1'b1, 1'b0, 1'b1}},
      // constructed sequence with a two byte long-form length
      '{8'h30, 1'b0, 1'b0, '0},
      '{8'h82, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0},
      // five length bytes saturate, content cut short by end of data
      '{8'h04, 1'b0, 1'b0, '0},
      '{8'h85, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1,
        '{KIND_CONTENT, 2'd0, 1'b0, 32'd4, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 1'b1}},
      // largest short tag, reserved length byte, truncated in the length
      '{8'hDE, 1'b0, 1'b1, '{KIND_ID, 2'd3, 1'b0, 32'd30, 32'd0, 8'hDE, 1'b0, 1'b0, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h01, 1'b1, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   atlv_req_if req_ch ();
   atlv_rsp_if rsp_ch ();

   asn1_tlv_stream_parser_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   parse_state_type prs;
   result_type      labels_due [$];
   body_byte_type   body_bytes [$];
   int unsigned     mismatches = 0;
   int unsigned     bytes_sent = 0;
   int unsigned     burst_left = 0;
   int unsigned     cycle_count = 0;

   // ---------------------------------------------------------------- model

   function automatic logic close_length();
      if (prs.length == 32'd0) begin
         prs.phase = PH_ID;
         return 1'b1;
      end
      prs.content_left = prs.length;
      prs.phase        = PH_CONTENT;
      return 1'b0;
   endfunction

   function automatic result_type label_byte(input logic [7:0] b, input logic eod);
      result_type  r;
      logic [38:0] tag_next;
      logic [39:0] len_next;
      logic        done;
      r    = '0;
      done = 1'b0;
      case (prs.phase)
         PH_HIGH: begin
            r.byte_kind = KIND_HIGH;
            tag_next    = {prs.tag, b[6:0]};
            if (tag_next[38:32] != 7'd0) begin
               prs.tag  = '1;
               prs.over = 1'b1;
            end else begin
               prs.tag = tag_next[31:0];
            end
            if (!b[7]) prs.phase = PH_LEN;
         end
         PH_LEN: begin
            r.byte_kind = KIND_LEN;
            if (b[7]) begin
               prs.length   = 32'd0;
               prs.len_left = b[6:0];
               if (b[6:0] == 7'd0) done = close_length();
               else prs.phase = PH_LONG;
            end else begin
               prs.length = {24'd0, b};
               done       = close_length();
            end
         end
         PH_LONG: begin
            r.byte_kind = KIND_LONG;
            len_next    = {prs.length, b};
            if (len_next[39:32] != 8'd0) begin
               prs.length = '1;
               prs.over   = 1'b1;
            end else begin
               prs.length = len_next[31:0];
            end
            prs.len_left = prs.len_left - 7'd1;
            if (prs.len_left == 7'd0) done = close_length();
         end
         PH_CONTENT: begin
            r.byte_kind      = KIND_CONTENT;
            prs.content_left = prs.content_left - 32'd1;
            if (prs.content_left == 32'd0) begin
               prs.phase = PH_ID;
               done      = 1'b1;
            end
         end
         default: begin
            r.byte_kind      = KIND_ID;
            prs.cls          = b[7:6];
            prs.cons         = b[5];
            prs.length       = 32'd0;
            prs.len_left     = 7'd0;
            prs.content_left = 32'd0;
            prs.over         = 1'b0;
            if (b[4:0] == TAG_ESCAPE) begin
               prs.tag   = 32'd0;
               prs.phase = PH_HIGH;
            end else begin
               prs.tag   = {27'd0, b[4:0]};
               prs.phase = PH_LEN;
            end
         end
      endcase
      if (eod && !done) begin
         done        = 1'b1;
         r.truncated = 1'b1;
         prs.phase   = PH_ID;
      end
      r.tag_class      = prs.cls;
      r.constructed    = prs.cons;
      r.tag_number     = prs.tag;
      r.content_length = prs.length;
      r.byte_out       = b;
      r.element_end    = done;
      r.oversize       = prs.over;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // one element: identifier, optional high tag bytes, length, content
   task automatic queue_element();
      logic [7:0]    elem [$];
      logic [7:0]    id;
      int unsigned   n_high, n_len, body_len, pick, cut, keep;
      bit            huge;
      body_byte_type bb;
      huge     = 1'b0;
      body_len = 0;
      id       = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) id[4:0] = TAG_ESCAPE;
      elem = {elem, id};
      if (id[4:0] == TAG_ESCAPE) begin
         n_high = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3);
         for (int i = 0; i < n_high; i++)
            elem = {elem, {i != n_high - 1, 7'($urandom_range(0, 127))}};
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         body_len = $urandom_range(0, 12);
         elem = {elem, 8'(body_len)};
      end else if (pick == 6) begin
         elem = {elem, 8'h80};
      end else if (pick <= 8) begin
         // long form, with leading zero bytes when it has more than one length byte
         n_len    = $urandom_range(1, 3);
         body_len = $urandom_range(0, 24);
         elem = {elem, 8'h80 | 8'(n_len)};
         for (int i = n_len - 1; i >= 0; i--)
            elem = {elem, (i == 0) ? 8'(body_len) : 8'h00};
      end else begin
         // length far beyond the run, closed early by end of data
         huge  = 1'b1;
         n_len = ($urandom_range(0, 3) == 0) ? 127 : $urandom_range(4, 8);
         elem = {elem, 8'h80 | 8'(n_len)};
         keep = $urandom_range(1, 9);
         for (int i = 0; i < keep; i++) elem = {elem, 8'($urandom_range(0, 255))};
      end
      for (int i = 0; i < body_len; i++) elem = {elem, 8'($urandom_range(0, 255))};
      cut = elem.size();
      if (!huge && $urandom_range(0, 15) == 0) cut = $urandom_range(1, elem.size());
      for (int i = 0; i < cut; i++) begin
         bb.data = elem[i];
         bb.eod  = 1'b0;
         if (i == cut - 1)
            bb.eod = huge || (cut != elem.size()) || ($urandom_range(0, 5) == 0);
         body_bytes = {body_bytes, bb};
      end
   endtask

   // random bytes, closed with end of data so the parser resynchronises
   task automatic queue_noise();
      body_byte_type bb;
      int unsigned   n;
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
         bb.data = 8'($urandom_range(0, 255));
         bb.eod  = (i == n - 1) || ($urandom_range(0, 3) == 0);
         body_bytes = {body_bytes, bb};
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic e, input logic fixed,
                            input result_type want);
      result_type model;
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.end_of_data <= e;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      bytes_sent++;
      model = label_byte(b, e);
      labels_due = {labels_due, fixed ? want : model};
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.data_byte   <= 8'h00;
      req_ch.end_of_data <= 1'b0;
      prs       = '0;
      prs.phase = PH_ID;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TABLE[i])
         send_byte(DIR_TABLE[i].data, DIR_TABLE[i].eod, DIR_TABLE[i].fixed, DIR_TABLE[i].want);

      while (body_bytes.size() < RANDOM_BYTES) begin
         if ($urandom_range(0, 9) == 0) queue_noise();
         else queue_element();
      end
      foreach (body_bytes[i]) send_byte(body_bytes[i].data, body_bytes[i].eod, 1'b0, '0);
      req_ch.valid <= 1'b0;

      while (labels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned rcv_cycle = 0;

   // stall pattern steps through four modes in turn; one long hold-off fills the pipe
   always @(posedge clock) begin
      rcv_cycle++;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && bytes_sent >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         case ((rcv_cycle / 64) % 4)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ch.ready <= (rcv_cycle % 4 != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (labels_due.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual byte %h",
                     $time, rsp_ch.byte_out);
            mismatches++;
         end else begin
            want = labels_due.pop_front();
            check_field("byte_kind", 32'(want.byte_kind), 32'(rsp_ch.byte_kind));
            check_field("tag_class", 32'(want.tag_class), 32'(rsp_ch.tag_class));
            check_field("constructed", 32'(want.constructed), 32'(rsp_ch.constructed));
            check_field("tag_number", want.tag_number, rsp_ch.tag_number);
            check_field("content_length", want.content_length, rsp_ch.content_length);
            check_field("byte_out", 32'(want.byte_out), 32'(rsp_ch.byte_out));
            check_field("element_end", 32'(want.element_end), 32'(rsp_ch.element_end));
            check_field("truncated", 32'(want.truncated), 32'(rsp_ch.truncated));
            check_field("oversize", 32'(want.oversize), 32'(rsp_ch.oversize));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

// File: asn1_tlv_stream_parser_top.f
+incdir+rtl
rtl/atlv_pkg.sv
rtl/atlv_req_if.sv
rtl/atlv_rsp_if.sv
rtl/atlv_core.sv
rtl/asn1_tlv_stream_parser_top.sv
dv/tb_asn1_tlv_stream_parser_top.sv
